// ===== src/latency_jitter_tracker_assert.svh =====
// Assertion macros shared by the tracker modules.
`ifndef LATENCY_JITTER_TRACKER_ASSERT_SVH
`define LATENCY_JITTER_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define LJT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LJT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LJT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LJT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/ljt_pkg.sv =====
package ljt_pkg;

	localparam int RING_DEPTH  = 16;
	localparam int MIN_SAMPLES = 2;
	localparam int LAT_W       = 16;
	localparam int HELD_W      = 5;
	localparam int PTR_W       = $clog2(RING_DEPTH);
	localparam int CNT_W       = $clog2(RING_DEPTH + 1);
	localparam int SUM_W       = LAT_W + CNT_W;
	localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

	typedef struct packed {
		logic             accept;
		logic             clr_acc;
		logic             rd_en;
		logic             rd_dev;
		logic [PTR_W-1:0] rd_addr;
		logic             div_start;
		logic             mean_ld;
		logic             jit_ld;
		logic             res_ld;
	} ljt_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic             div_done;
		logic             res_busy;
	} ljt_sts_t;

endpackage

// ===== src/ljt_sample_if.sv =====
interface ljt_sample_if;
	import ljt_pkg::*;

	logic             valid;
	logic             ready;
	logic [LAT_W-1:0] latency_sample;

	modport source (output valid, output latency_sample, input ready);
	modport sink   (input valid, input latency_sample, output ready);

endinterface

// ===== src/ljt_result_if.sv =====
interface ljt_result_if;
	import ljt_pkg::*;

	logic              valid;
	logic              ready;
	logic [LAT_W-1:0]  latest_latency;
	logic [LAT_W-1:0]  mean_latency;
	logic [LAT_W-1:0]  jitter;
	logic [HELD_W-1:0] samples_held;

	modport source (output valid, output latest_latency, output mean_latency,
		output jitter, output samples_held, input ready);
	modport sink   (input valid, input latest_latency, input mean_latency,
		input jitter, input samples_held, output ready);

endinterface

// ===== src/latency_jitter_tracker.sv =====
// channel  | dir | fields
// sample   | in  | latency_sample[15:0]
// result   | out | latest_latency[15:0] mean_latency[15:0] jitter[15:0] samples_held[4:0]
//
// One word in, one word out. With two or more samples held a word takes two read passes
// over the ring RAM plus two runs of the bit-serial divider; with one sample held both
// are skipped.
// Reset clears pointer, fill count and jitter; the ring needs no clearing.
// A new word is taken while the previous result waits; a stalled result holds the
// finished word in its last state.
module latency_jitter_tracker (
	input  logic         clk,
	input  logic         arst_n,
	ljt_sample_if.sink   sample,
	ljt_result_if.source result
);
	import ljt_pkg::*;

	ljt_cmd_t cmd;
	ljt_sts_t sts;

	ljt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(sample.valid),
		.in_ready(sample.ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	ljt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.latency_sample(sample.latency_sample),
		.res           (result)
	);

endmodule

// ===== src/ljt_ram.sv =====
module ljt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/ljt_div.sv =====
`include "latency_jitter_tracker_assert.svh"

module ljt_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ljt_pkg::SUM_W-1:0] dividend,
	input  logic [ljt_pkg::CNT_W-1:0] divisor,
	output logic [ljt_pkg::SUM_W-1:0] quotient,
	output logic                      done
);
	import ljt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     divisor_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W:0]       trial;
	logic                 fits;

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= CNT_W'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

	`LJT_ASSERT_IMPLY(a_rem_below_divisor, clk, arst_n, busy_q, rem_q < divisor_q)
	`LJT_ASSERT_NEXT(a_start_runs, clk, arst_n, start, busy_q)

endmodule

// ===== src/ljt_dp.sv =====
`include "latency_jitter_tracker_assert.svh"

module ljt_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ljt_pkg::ljt_cmd_t         cmd,
	output ljt_pkg::ljt_sts_t         sts,
	input  logic [ljt_pkg::LAT_W-1:0] latency_sample,
	ljt_result_if.source              res
);
	import ljt_pkg::*;

	logic [PTR_W-1:0]  wptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic [LAT_W-1:0]  sample_q;
	logic [LAT_W-1:0]  mean_q;
	logic [LAT_W-1:0]  jitter_q;
	logic [SUM_W-1:0]  acc_q;
	logic              rd_en_s1;
	logic              rd_dev_s1;
	logic              res_valid_q;
	logic [LAT_W-1:0]  res_latest_q;
	logic [LAT_W-1:0]  res_mean_q;
	logic [LAT_W-1:0]  res_jitter_q;
	logic [HELD_W-1:0] res_held_q;
	logic [LAT_W-1:0]  rd_data;
	logic [LAT_W-1:0]  dev_abs;
	logic [SUM_W-1:0]  quotient;
	logic              div_done;

	ljt_ram #(
		.WIDTH(LAT_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (cmd.accept),
		.waddr(wptr_q),
		.wdata(latency_sample),
		.re   (cmd.rd_en),
		.raddr(cmd.rd_addr),
		.rdata(rd_data)
	);

	ljt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(acc_q),
		.divisor (fill_q),
		.quotient(quotient),
		.done    (div_done)
	);

	assign dev_abs = (rd_data >= mean_q) ? (rd_data - mean_q) : (mean_q - rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			fill_q      <= '0;
			jitter_q    <= '0;
			rd_en_s1    <= 1'b0;
			rd_dev_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_en_s1  <= cmd.rd_en;
			rd_dev_s1 <= cmd.rd_dev;
			if (cmd.accept) begin
				if (wptr_q == PTR_W'(RING_DEPTH - 1)) begin
					wptr_q <= '0;
				end else begin
					wptr_q <= wptr_q + PTR_W'(1);
				end
				if (fill_q != CNT_W'(RING_DEPTH)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (cmd.jit_ld) begin
				jitter_q <= quotient[LAT_W-1:0];
			end
			if (cmd.res_ld) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= latency_sample;
			mean_q   <= '0;
		end else if (cmd.mean_ld) begin
			mean_q <= quotient[LAT_W-1:0];
		end
		if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (rd_en_s1) begin
			acc_q <= acc_q + (rd_dev_s1 ? SUM_W'(dev_abs) : SUM_W'(rd_data));
		end
		if (cmd.res_ld) begin
			res_latest_q <= sample_q;
			res_mean_q   <= mean_q;
			res_jitter_q <= jitter_q;
			res_held_q   <= HELD_W'(fill_q);
		end
	end

	assign sts.fill     = fill_q;
	assign sts.div_done = div_done;
	assign sts.res_busy = res_valid_q && !res.ready;

	assign res.valid          = res_valid_q;
	assign res.latest_latency = res_latest_q;
	assign res.mean_latency   = res_mean_q;
	assign res.jitter         = res_jitter_q;
	assign res.samples_held   = res_held_q;

	`LJT_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, cmd.res_ld, !res_valid_q || res.ready)

endmodule

// ===== src/ljt_ctrl.sv =====
`include "latency_jitter_tracker_assert.svh"

module ljt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output ljt_pkg::ljt_cmd_t cmd,
	input  ljt_pkg::ljt_sts_t sts
);
	import ljt_pkg::*;

	typedef enum logic [3:0] {
		IDLE,
		CHECK,
		RD_SUM,
		SUM_TAIL,
		MEAN_GO,
		DIV_MEAN,
		RD_DEV,
		DEV_TAIL,
		DEV_GO,
		DIV_DEV,
		FINISH
	} state_t;

	state_t           state_q;
	logic [PTR_W-1:0] idx_q;
	logic             last_rd;

	assign last_rd = (CNT_W'(idx_q) + CNT_W'(1)) == sts.fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					idx_q <= '0;
					if (sts.fill < CNT_W'(MIN_SAMPLES)) begin
						state_q <= FINISH;
					end else begin
						state_q <= RD_SUM;
					end
				end
				RD_SUM: begin
					if (last_rd) begin
						state_q <= SUM_TAIL;
					end else begin
						idx_q <= idx_q + PTR_W'(1);
					end
				end
				SUM_TAIL: state_q <= MEAN_GO;
				MEAN_GO:  state_q <= DIV_MEAN;
				DIV_MEAN: begin
					if (sts.div_done) begin
						idx_q   <= '0;
						state_q <= RD_DEV;
					end
				end
				RD_DEV: begin
					if (last_rd) begin
						state_q <= DEV_TAIL;
					end else begin
						idx_q <= idx_q + PTR_W'(1);
					end
				end
				DEV_TAIL: state_q <= DEV_GO;
				DEV_GO:   state_q <= DIV_DEV;
				DIV_DEV: begin
					if (sts.div_done) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (!sts.res_busy) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.rd_addr = idx_q;
		case (state_q)
			IDLE:     cmd.accept = in_valid;
			CHECK:    cmd.clr_acc = 1'b1;
			RD_SUM:   cmd.rd_en = 1'b1;
			MEAN_GO: begin
				cmd.div_start = 1'b1;
				cmd.clr_acc   = 1'b1;
			end
			DIV_MEAN: cmd.mean_ld = sts.div_done;
			RD_DEV: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_dev = 1'b1;
			end
			DEV_GO:   cmd.div_start = 1'b1;
			DIV_DEV:  cmd.jit_ld = sts.div_done;
			FINISH:   cmd.res_ld = !sts.res_busy;
			default:  cmd.rd_addr = idx_q;
		endcase
	end

	assign in_ready = (state_q == IDLE);

	`LJT_ASSERT_NEXT(a_accept_to_check, clk, arst_n, in_valid && in_ready, state_q == CHECK)
	`LJT_ASSERT_IMPLY(a_read_in_fill, clk, arst_n, cmd.rd_en, CNT_W'(idx_q) < sts.fill)

endmodule

// ===== sim/tb_latency_jitter_tracker.sv =====
`timescale 1ns / 1ps

module tb_latency_jitter_tracker;
	import ljt_pkg::*;

	localparam int MAX_GAP     = 18;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 100;
	localparam int LONG_HOLD   = 300;

	typedef struct packed {
		logic [LAT_W-1:0]  latest;
		logic [LAT_W-1:0]  mean;
		logic [LAT_W-1:0]  jitter;
		logic [HELD_W-1:0] held;
	} jitter_word_t;

	logic clk;
	logic arst_n;

	ljt_sample_if sample_ch ();
	ljt_result_if result_ch ();

	latency_jitter_tracker uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	// predictor state
	logic [LAT_W-1:0] ring_model [RING_DEPTH];
	int unsigned      wr_ptr       = 0;
	int unsigned      fill_model   = 0;
	logic [LAT_W-1:0] jitter_model = '0;

	jitter_word_t expected_words [$];
	int           errors     = 0;
	int           idle_count = 0;
	bit           tx_idle_on = 1'b1;
	bit           rx_idle_on = 1'b1;
	int           rx_hold    = 0;
	logic [LAT_W-1:0] spread_base = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic jitter_word_t track_latency(logic [LAT_W-1:0] lat);
		int unsigned  sum;
		int unsigned  dev;
		int unsigned  avg;
		jitter_word_t w;
		sum = 0;
		dev = 0;
		avg = 0;
		ring_model[wr_ptr] = lat;
		wr_ptr = (wr_ptr + 1 >= RING_DEPTH) ? 0 : wr_ptr + 1;
		if (fill_model < RING_DEPTH) begin
			fill_model++;
		end
		if (fill_model >= MIN_SAMPLES) begin
			for (int i = 0; i < fill_model; i++)
				sum += ring_model[i];
			avg = sum / fill_model;
			for (int i = 0; i < fill_model; i++)
				dev += (ring_model[i] >= avg) ? ring_model[i] - avg : avg - ring_model[i];
			jitter_model = LAT_W'(dev / fill_model);
		end
		w.latest = lat;
		w.mean   = LAT_W'(avg);
		w.jitter = jitter_model;
		w.held   = HELD_W'(fill_model);
		return w;
	endfunction

	function automatic logic [LAT_W-1:0] pick_latency();
		logic [LAT_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = LAT_W'($urandom());
			1: v = LAT_W'($urandom_range(0, 400));
			2: v = spread_base + LAT_W'($urandom_range(0, 63));
			default: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = '1;
					2: v = 16'h0001;
					3: v = 16'hFFFE;
					default: v = 16'h8000;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
	endtask

	// starts and ends at a falling edge; valid stays high after acceptance
	task automatic send_word(logic [LAT_W-1:0] lat);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid          <= 1'b1;
		sample_ch.latency_sample <= lat;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		expected_words.push_back(track_latency(lat));
		@(negedge clk);
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (expected_words.size() != 0);
	endtask

	task automatic compare_result();
		jitter_word_t want;
		if (expected_words.size() == 0) begin
			report_mismatch("unexpected word", result_ch.latest_latency, 0);
		end else begin
			want = expected_words.pop_front();
			if (result_ch.latest_latency !== want.latest)
				report_mismatch("latest_latency", result_ch.latest_latency, want.latest);
			if (result_ch.mean_latency !== want.mean)
				report_mismatch("mean_latency", result_ch.mean_latency, want.mean);
			if (result_ch.jitter !== want.jitter)
				report_mismatch("jitter", result_ch.jitter, want.jitter);
			if (result_ch.samples_held !== want.held)
				report_mismatch("samples_held", result_ch.samples_held, want.held);
		end
	endtask

	initial begin : result_sink
		int gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				gap     = rx_hold;
				rx_hold = 0;
			end else begin
				gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
			compare_result();
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("[latency_jitter_tracker] ERROR");
			$finish;
		end
	end

	// single sample, extremes, full ring of mostly 16'hFFFF, wrap
	task automatic test_directed();
		logic [LAT_W-1:0] seq [$];
		seq = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001,
			16'hFFFE};
		repeat (12) seq.push_back(16'hFFFF);
		repeat (3) seq.push_back(16'h0000);
		foreach (seq[i])
			send_word(seq[i]);
		drain_results();
	endtask

	task automatic test_random_mix(int count);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (count) begin
			if ($urandom_range(0, 15) == 0)
				spread_base = LAT_W'($urandom());
			send_word(pick_latency());
		end
	endtask

	task automatic test_full_rate(int count);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (count)
			send_word(pick_latency());
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_result_backpressure(int count);
		tx_idle_on = 1'b0;
		rx_hold    = LONG_HOLD;
		repeat (count)
			send_word(pick_latency());
		tx_idle_on = 1'b1;
		drain_results();
	endtask

	task automatic test_sender_pause(int bursts);
		repeat (bursts) begin
			repeat ($urandom_range(1, 40))
				send_word(pick_latency());
			drain_results();
		end
	endtask

	initial begin
		sample_ch.valid          = 1'b0;
		sample_ch.latency_sample = '0;
		arst_n                   = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_mix(220);
		test_full_rate(120);
		test_result_backpressure(40);
		test_sender_pause(6);
		test_random_mix(40);

		drain_results();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("[latency_jitter_tracker] OK");
		end else begin
			$display("[latency_jitter_tracker] ERROR");
		end
		$finish;
	end

endmodule
